FILE: hdl/mpi_pkg.sv
// ----------------------------------------------------------------------------
// mpi_pkg
// Shared types, constants and helpers of the Mandelbrot pixel iterator.
// ----------------------------------------------------------------------------
package mpi_pkg;

   // image geometry (power-of-two sizes, mapping divides by shifting)
   localparam int IMG_W_LOG2   = 8;
   localparam int IMG_H_LOG2   = 8;
   localparam int IMAGE_WIDTH  = 1 << IMG_W_LOG2;
   localparam int IMAGE_HEIGHT = 1 << IMG_H_LOG2;
   localparam int IDX_BITS     = IMG_W_LOG2 + IMG_H_LOG2;
   localparam int PIX_COUNT    = 1 << IDX_BITS;

   localparam int FRAC_BITS = 28;
   localparam logic [63:0] ESCAPE_Q56 = 64'h0400_0000_0000_0000;

   localparam logic [7:0] PIX_BOUNDED = 8'd0;
   localparam logic [7:0] PIX_ESCAPED = 8'd255;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_SPAN_X   = 3'd0,
      CSR_SPAN_Y   = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_ITER_CNT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [30:0]        span_x;
      logic [30:0]        span_y;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [15:0]        iter_count;
   } cfg_type;

   // one classified pixel: store index and its point c
   typedef struct packed {
      logic [IDX_BITS-1:0] idx;
      logic signed [31:0]  cr;
      logic signed [31:0]  ci;
   } item_type;

   // saturate a wide signed sum to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/mandelbrot_pixel_iterator.sv
// ----------------------------------------------------------------------------
// mandelbrot_pixel_iterator
// Escape-time iteration of a 256x256 image, z kept per pixel across words.
//
// req_ channel: one pixel coordinate word per handshake. rsp_ channel: one
// pixel_value word (0 bounded, 255 escaped) per request, in order.
// csr_ channel: register index and data, always ready; write only when idle.
// The front maps the coordinate to c from a registered product and queues it
// (two entries); the back reads the pixel's z, squares it, then runs each
// z update through states CHK, MRI, UPD, SQR and SQI on one shared 32x32
// multiplier. The default iteration count is ten; an escaped pixel finishes
// after its first squares.
// After reset the pixel store is cleared, all 65536 entries, during which no
// request word is taken. A stalled rsp_ side holds one finished word; the
// back then waits to write back while the front keeps filling its queue.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_iterator
   import mpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // pixel_x[7:0], pixel_y[15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pixel_value[7:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type  cfg_ff;
   item_type fe_data, q_data;
   logic     fe_valid, fe_ready, q_valid, q_ready, be_ready;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.span_x     <= 31'h1000_0000;
         cfg_ff.span_y     <= 31'h1000_0000;
         cfg_ff.center_x   <= '0;
         cfg_ff.center_y   <= '0;
         cfg_ff.iter_count <= 16'd10;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SPAN_X:   cfg_ff.span_x     <= csr_data[30:0];
            CSR_SPAN_Y:   cfg_ff.span_y     <= csr_data[30:0];
            CSR_CENTER_X: cfg_ff.center_x   <= csr_data;
            CSR_CENTER_Y: cfg_ff.center_y   <= csr_data;
            CSR_ITER_CNT: cfg_ff.iter_count <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   mpi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .enable    (be_ready),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pixel_x   (req_tdata[7:0]),
      .pixel_y   (req_tdata[15:8]),
      .out_valid (fe_valid),
      .out_ready (fe_ready),
      .out_data  (fe_data)
   );

   mpi_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fe_valid),
      .wr_ready (fe_ready),
      .wr_data  (fe_data),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   mpi_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .ready_for_items (be_ready),
      .in_valid        (q_valid),
      .in_ready        (q_ready),
      .in_data         (q_data),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_data        (rsp_tdata)
   );

endmodule

FILE: hdl/mpi_fifo.sv
// ----------------------------------------------------------------------------
// mpi_fifo
// Two-entry queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module mpi_fifo
   import mpi_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  item_type wr_data,
   output logic     rd_valid,
   input  logic     rd_ready,
   output item_type rd_data
);

   item_type   mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

FILE: hdl/mpi_front.sv
// ----------------------------------------------------------------------------
// mpi_front
// Accepts pixel words and maps each coordinate to the point c.
// ----------------------------------------------------------------------------
module mpi_front
   import mpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        enable,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  pixel_x,
   input  logic [7:0]  pixel_y,
   output logic        out_valid,
   input  logic        out_ready,
   output item_type    out_data
);

   logic                     st_valid_ff;
   logic [IDX_BITS-1:0]      st_idx_ff;
   logic signed [40:0]       px_prod_ff, py_prod_ff;
   logic signed [8:0]        dx, dy;
   logic signed [40:0]       qx_adj, qy_adj;
   logic signed [39:0]       qx, qy;
   logic                     take;

   assign dx = $signed({1'b0, pixel_x}) - 9'sd128;
   assign dy = $signed({1'b0, pixel_y}) - 9'sd128;

   assign in_ready  = enable && (!st_valid_ff || out_ready);
   assign take      = in_valid && in_ready;
   assign out_valid = st_valid_ff;

   // stage: span times offset from the image center
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else if (take) begin
         st_valid_ff <= 1'b1;
      end else if (out_ready) begin
         st_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         st_idx_ff  <= {pixel_y, pixel_x};
         px_prod_ff <= $signed({1'b0, cfg.span_x}) * dx;
         py_prod_ff <= $signed({1'b0, cfg.span_y}) * dy;
      end
   end

   // divide truncating toward zero, then add center_x to the real part and subtract center_y from the imaginary part
   assign qx_adj = px_prod_ff + (px_prod_ff[40] ? 41'sd255 : 41'sd0);
   assign qy_adj = py_prod_ff + (py_prod_ff[40] ? 41'sd255 : 41'sd0);
   assign qx     = 40'(qx_adj >>> IMG_W_LOG2);
   assign qy     = 40'(qy_adj >>> IMG_H_LOG2);

   assign out_data.idx = st_idx_ff;
   assign out_data.cr  = sat32(qx + 40'(cfg.center_x));
   assign out_data.ci  = sat32(qy - 40'(cfg.center_y));

endmodule

FILE: hdl/mpi_back.sv
// ----------------------------------------------------------------------------
// mpi_back
// Runs the z iteration of one pixel on a shared multiplier, keeps per-pixel
// z and escape bit in a memory, and holds the result word.
// ----------------------------------------------------------------------------
module mpi_back
   import mpi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   output logic       ready_for_items,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_SQR, ST_SQI, ST_CHK, ST_MRI, ST_UPD, ST_WB
   } state_type;

   state_type           state_ff;
   logic [64:0]         mem [PIX_COUNT];
   logic [64:0]         rd_ff;
   logic                clr_busy_ff;
   logic [IDX_BITS-1:0] clr_addr_ff;
   item_type            cur_ff;
   logic signed [31:0]  zr_ff, zi_ff;
   logic signed [63:0]  rr_ff, ii_ff, ri_ff;
   logic                esc_ff, first_ff;
   logic [15:0]         n_ff;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_data_ff;
   logic signed [31:0]  mul_a, mul_b;
   logic signed [63:0]  prod;
   logic [63:0]         mag;
   logic                esc_now, wb_go;
   logic signed [63:0]  diff;
   logic signed [39:0]  nr_sum, ni_sum;

   assign ready_for_items = !clr_busy_ff;
   assign in_ready  = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // shared multiplier
   always_comb begin
      case (state_ff)
         ST_SQI:  begin mul_a = zi_ff; mul_b = zi_ff; end
         ST_MRI:  begin mul_a = zr_ff; mul_b = zi_ff; end
         default: begin mul_a = zr_ff; mul_b = zr_ff; end
      endcase
   end
   assign prod = mul_a * mul_b;

   // escape test and z update
   assign mag     = 64'(rr_ff) + 64'(ii_ff);
   assign esc_now = esc_ff || (!first_ff && (mag >= ESCAPE_Q56));
   assign diff    = rr_ff - ii_ff;
   assign nr_sum  = 40'(diff >>> FRAC_BITS) + 40'(cur_ff.cr);
   assign ni_sum  = 40'(ri_ff >>> (FRAC_BITS - 1)) + 40'(cur_ff.ci);
   assign wb_go   = (state_ff == ST_WB) && (!rsp_valid_ff || rsp_ready);

   // pixel store: clearing pass after reset, write-back, registered read
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wb_go) begin
         mem[cur_ff.idx] <= {esc_ff, zi_ff, zr_ff};
      end
      rd_ff <= mem[in_data.idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == IDX_BITS'(PIX_COUNT - 1)) clr_busy_ff <= 1'b0;
      end
   end

   // iteration sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= wb_go || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_IDLE: begin
               if (in_valid && in_ready) begin
                  cur_ff   <= in_data;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               zr_ff    <= rd_ff[31:0];
               zi_ff    <= rd_ff[63:32];
               esc_ff   <= rd_ff[64];
               first_ff <= 1'b1;
               n_ff     <= '0;
               state_ff <= ST_SQR;
            end
            ST_SQR: begin
               rr_ff    <= prod;
               state_ff <= ST_SQI;
            end
            ST_SQI: begin
               ii_ff    <= prod;
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               esc_ff   <= esc_now;
               first_ff <= 1'b0;
               if (esc_now || (n_ff == cfg.iter_count)) state_ff <= ST_WB;
               else state_ff <= ST_MRI;
            end
            ST_MRI: begin
               ri_ff    <= prod;
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               zr_ff    <= sat32(nr_sum);
               zi_ff    <= sat32(ni_sum);
               n_ff     <= n_ff + 16'd1;
               state_ff <= ST_SQR;
            end
            ST_WB: begin
               if (wb_go) begin
                  rsp_data_ff  <= esc_ff ? PIX_ESCAPED : PIX_BOUNDED;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
